### design/alsd_pkg.sv
// Shared types, codes and constants for the array list search and delete block.
package alsd_pkg;

  // Default number of list entries.
  localparam int LIST_DEPTH_DEF = 16;

  // Request kinds. The fourth code is a no-operation.
  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_DELETE = 2'd2
  } kind_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_MISSING = 2'd2
  } status_t;

  // One request transaction.
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] value;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic [1:0] status;
    logic [3:0] position;
    logic [4:0] entry_count;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    cap;        // capture the accepted request
    logic    ins;        // append the request value if there is room
    logic    scan_init;  // start a scan at the newest entry
    logic    scan_rd;    // read the next older entry
    logic    hit_take;   // record the matching index, prepare the shift
    logic    shift_rd;   // read the next entry above the gap
    logic    shift_wr;   // write the entry read last one place lower
    logic    cnt_dec;    // one entry fewer
    logic    res_load;   // load the result register
    status_t res_status; // status for the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] kind;     // kind of the captured request
    logic       full;     // list holds its maximum number of entries
    logic       hit;      // entry read last equals the request value
    logic       cmp_vld;  // a read is waiting to be compared or written
    logic       ptr_zero; // scan pointer reached the oldest entry
    logic       ptr_end;  // shift pointer reached the fill count
    logic       out_free; // result register can take a new result
  } stat_t;

endpackage

### design/alsd_ctrl.sv
// Controller state machine that sequences insert, scan and shift steps.
module alsd_ctrl
  import alsd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t  state_r, state_nxt;
  status_t st_r, st_nxt;

  // State and pending result status registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= STAT_DONE;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt      = state_r;
    st_nxt         = st_r;
    cmd            = '0;
    cmd.res_status = st_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.kind)
          KIND_INSERT: begin
            cmd.ins   = 1'b1;
            st_nxt    = stat.full ? STAT_FULL : STAT_DONE;
            state_nxt = S_DONE;
          end
          KIND_SEARCH, KIND_DELETE: begin
            cmd.scan_init = 1'b1;
            state_nxt     = S_SCAN;
          end
          default: begin
            st_nxt    = STAT_DONE;
            state_nxt = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        if (stat.hit) begin
          cmd.hit_take = 1'b1;
          st_nxt       = STAT_DONE;
          state_nxt    = (stat.kind == KIND_DELETE) ? S_SHIFT : S_DONE;
        end else if (stat.ptr_zero) begin
          st_nxt    = STAT_MISSING;
          state_nxt = S_DONE;
        end else begin
          cmd.scan_rd = 1'b1;
        end
      end
      S_SHIFT: begin
        // Each entry read is written one place lower on the next cycle.
        cmd.shift_wr = stat.cmp_vld;
        if (!stat.ptr_end) begin
          cmd.shift_rd = 1'b1;
        end else if (!stat.cmp_vld) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### design/alsd_dpath.sv
// Datapath: entry memory, fill count, scan pointer, compare and result register.
module alsd_dpath
  import alsd_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  cmd_t      cmd,
  output stat_t     stat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int IDX_W = $clog2(LIST_DEPTH);
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  logic [31:0]      mem [LIST_DEPTH];
  in_item_t         item_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] ptr_r;
  logic [IDX_W-1:0] pos_r;
  logic [31:0]      rd_data_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic             cmp_vld_r;
  logic             out_valid_r;
  out_item_t        out_data_r;

  logic             full;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [CNT_W-1:0] ptr_m1;
  logic             we;
  logic [IDX_W-1:0] wa;
  logic [31:0]      wd;
  logic [31:0]      pos_ext;
  logic [31:0]      cnt_ext;

  assign full   = (count_r == DEPTH_C);
  assign ptr_m1 = ptr_r - ONE_C;

  // Read port: scans walk downward, shifts walk upward.
  assign rd_en   = cmd.scan_rd | cmd.shift_rd;
  assign rd_addr = cmd.scan_rd ? ptr_m1[IDX_W-1:0] : ptr_r[IDX_W-1:0];

  // Write port: an append at the fill count or a shift one place down.
  always_comb begin
    we = 1'b0;
    wa = count_r[IDX_W-1:0];
    wd = item_r.value;
    if (cmd.ins && !full) begin
      we = 1'b1;
    end else if (cmd.shift_wr) begin
      we = 1'b1;
      wa = cmp_idx_r - IDX_W'(1);
      wd = rd_data_r;
    end
  end

  // Entry memory with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      cmp_idx_r <= rd_addr;
    end
  end

  // Read tracking and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
      count_r   <= '0;
    end else begin
      cmp_vld_r <= rd_en;
      if (cmd.ins && !full) begin
        count_r <= count_r + ONE_C;
      end else if (cmd.cnt_dec) begin
        count_r <= count_r - ONE_C;
      end
    end
  end

  // Request capture, pointer and position.
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      item_r <= in_data;
      pos_r  <= '0;
    end
    if (cmd.ins && !full) begin
      pos_r <= count_r[IDX_W-1:0];
    end
    if (cmd.scan_init) begin
      ptr_r <= count_r;
    end else if (cmd.scan_rd) begin
      ptr_r <= ptr_m1;
    end else if (cmd.hit_take) begin
      pos_r <= cmp_idx_r;
      ptr_r <= CNT_W'(cmp_idx_r) + ONE_C;
    end else if (cmd.shift_rd) begin
      ptr_r <= ptr_r + ONE_C;
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.kind     = item_r.kind;
    stat.full     = full;
    stat.hit      = cmp_vld_r && (rd_data_r == item_r.value);
    stat.cmp_vld  = cmp_vld_r;
    stat.ptr_zero = (ptr_r == '0);
    stat.ptr_end  = (ptr_r == count_r);
    stat.out_free = !out_valid_r || !out_stall;
  end

  assign pos_ext = 32'(pos_r);
  assign cnt_ext = 32'(count_r);

  // Result register; a finished result waits here while the next request enters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_data_r.status      <= cmd.res_status;
      out_data_r.position    <= (cmd.res_status == STAT_DONE) ? pos_ext[3:0] : 4'd0;
      out_data_r.entry_count <= cnt_ext[4:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### design/array_list_search_delete.sv
// Top level of the array list search and delete block.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid/in_stall    in_item_t (kind, value)
//   out_     output     out_valid/out_stall  out_item_t (status, position, entry_count)
//
// One request is worked on at a time. An insert or a no-operation passes from
// acceptance through the execute state to the done state. A search scans from
// the newest entry downward. A delete then shifts every entry above the removed
// one a place lower; the single read and write port of the entry memory moves
// one entry a cycle. Reset clears the fill count; no clearing pass is needed.
// A stalled result waits in the output register while the next request is
// accepted and worked on.
module array_list_search_delete
  import alsd_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  cmd_t  cmd;
  stat_t stat;

  // Controller.
  alsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath.
  alsd_dpath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### bench/tb_array_list_search_delete.sv
// Self-checking testbench for the array list search and delete block.
module tb_array_list_search_delete
  import alsd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // The unused fourth request code does nothing but report the count.
  localparam logic [1:0] KIND_NOOP = 2'd3;
  localparam int STUCK_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 50;
  localparam int PHASE_ITEMS = 584;
  localparam int MODE_SPAN = 40;

  // Traffic shapes for the random part.
  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_t;

  // Shadow list that predicts every result and checks it in order.
  class list_scoreboard;
    logic [31:0] shadow[LIST_DEPTH_DEF];
    int held;
    out_item_t due_results[$];
    int err_count;

    function new();
      held = 0;
      err_count = 0;
    endfunction

    // Index of the newest entry equal to val, or -1 when there is none.
    function int newest_match(logic [31:0] val);
      for (int i = held - 1; i >= 0; i--) begin
        if (shadow[i] == val) begin
          return i;
        end
      end
      return -1;
    endfunction

    // Apply one accepted request to the shadow list and queue its result.
    function void note_request(in_item_t req);
      out_item_t res;
      int hit;
      res = '0;
      res.status = STAT_DONE;
      hit = newest_match(req.value);
      case (req.kind)
        KIND_INSERT: begin
          if (held >= LIST_DEPTH_DEF) begin
            res.status = STAT_FULL;
          end else begin
            shadow[held] = req.value;
            res.position = 4'(held);
            held++;
          end
        end
        KIND_SEARCH: begin
          if (hit < 0) begin
            res.status = STAT_MISSING;
          end else begin
            res.position = 4'(hit);
          end
        end
        KIND_DELETE: begin
          if (hit < 0) begin
            res.status = STAT_MISSING;
          end else begin
            res.position = 4'(hit);
            for (int i = hit; i + 1 < held; i++) begin
              shadow[i] = shadow[i + 1];
            end
            held--;
          end
        end
        default: ;
      endcase
      res.entry_count = 5'(held);
      due_results.push_back(res);
    endfunction

    // Print one mismatch line and count it.
    task report(string what, int got, int want);
      $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
      err_count++;
    endtask

    // Compare one accepted result with the oldest prediction.
    task check_result(out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        report("unexpected result, status", got.status, 0);
        return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status) report("status", got.status, want.status);
      if (got.position !== want.position) report("position", got.position, want.position);
      if (got.entry_count !== want.entry_count) begin
        report("entry_count", got.entry_count, want.entry_count);
      end
    endtask

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  list_scoreboard sb = new();
  int send_idle_pct = 37;
  int recv_idle_pct = 51;
  int stuck_cycles = 0;
  bit moved;
  logic [31:0] value_pool[8];

  array_list_search_delete dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Receiver stalls, transaction monitors and the watchdog.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
    if (rst_n) begin
      moved = 1'b0;
      if (in_valid && !in_stall) begin
        sb.note_request(in_data);
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        sb.check_result(out_data);
        moved = 1'b1;
      end
      stuck_cycles = moved ? 0 : stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("tb_array_list_search_delete: done, errors");
        $finish;
      end
    end
  end

  function automatic in_item_t make_request(logic [1:0] kind, logic [31:0] val);
    in_item_t it;
    it.kind = kind;
    it.value = val;
    return it;
  endfunction

  // Random request: kinds weighted by traffic shape, values mostly reused so
  // that searches and deletes hit and duplicates occur.
  function automatic in_item_t random_request(traffic_t mode);
    int roll;
    int ins_pct;
    int del_pct;
    logic [1:0] kind;
    logic [31:0] val;
    ins_pct = (mode == MODE_FILL) ? 65 : (mode == MODE_DRAIN) ? 20 : 40;
    del_pct = (mode == MODE_FILL) ? 15 : (mode == MODE_DRAIN) ? 55 : 28;
    roll = $urandom_range(99);
    if (roll < ins_pct) kind = KIND_INSERT;
    else if (roll < ins_pct + del_pct) kind = KIND_DELETE;
    else if (roll < 96) kind = KIND_SEARCH;
    else kind = KIND_NOOP;
    roll = $urandom_range(99);
    if (kind == KIND_INSERT) begin
      if (roll < 50) begin
        val = value_pool[$urandom_range(7)];
      end else if (roll < 70) begin
        val = 32'($urandom_range(8)) - 32'd4;
      end else begin
        val = $urandom;
        value_pool[$urandom_range(7)] = val;
      end
    end else begin
      if (roll < 70) val = value_pool[$urandom_range(7)];
      else if (roll < 80) val = 32'($urandom_range(8)) - 32'd4;
      else val = $urandom;
    end
    return make_request(kind, val);
  endfunction

  // Offer one request, idling first at the current rate, until accepted.
  task automatic send_request(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold the sender off until every predicted result has arrived.
  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Reset, directed requests, then three phases of random traffic.
  initial begin
    for (int i = 0; i < 8; i++) value_pool[i] = $urandom;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Empty list, no-operation, extreme values, duplicates and shifts.
    send_request(make_request(KIND_SEARCH, 32'h0000_0000));
    send_request(make_request(KIND_DELETE, 32'h0000_0000));
    send_request(make_request(KIND_NOOP, 32'hFFFF_FFFF));
    send_request(make_request(KIND_INSERT, 32'h8000_0000));
    send_request(make_request(KIND_INSERT, 32'h7FFF_FFFF));
    send_request(make_request(KIND_INSERT, 32'hFFFF_FFFF));
    send_request(make_request(KIND_INSERT, 32'h0000_0000));
    send_request(make_request(KIND_INSERT, 32'h0000_0005));
    send_request(make_request(KIND_INSERT, 32'h0000_0005));
    send_request(make_request(KIND_SEARCH, 32'h0000_0005));
    send_request(make_request(KIND_DELETE, 32'h0000_0005));
    send_request(make_request(KIND_SEARCH, 32'h0000_0005));
    send_request(make_request(KIND_SEARCH, 32'h7FFF_FFFF));
    send_request(make_request(KIND_DELETE, 32'h8000_0000));
    send_request(make_request(KIND_SEARCH, 32'hFFFF_FFFF));
    send_request(make_request(KIND_SEARCH, 32'h8000_0000));
    send_request(make_request(KIND_DELETE, 32'h0001_2345));
    send_request(make_request(KIND_NOOP, 32'h0000_0000));

    for (int phase = 0; phase < 3; phase++) begin
      wait_all_results();
      send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 51 : 0;
      recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 37 : 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_request(random_request(traffic_t'((i / MODE_SPAN) % 3)));
      end
    end

    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.err_count == 0) begin
      $display("tb_array_list_search_delete: done, clean");
    end else begin
      $display("tb_array_list_search_delete: done, errors");
    end
    $finish;
  end

endmodule
